// ===== sv/mdt_pkg.sv =====
// Shared constants, types and helper functions of the distance transform.
`timescale 1ns / 1ps

package mdt_pkg;

  // Bitmap geometry
  localparam int MAX_DIM  = 256;
  localparam int IDX_W    = $clog2(MAX_DIM);
  localparam int ADDR_W   = 2 * IDX_W;
  localparam int DEPTH    = 1 << ADDR_W;
  localparam int DIM_W    = IDX_W + 1;

  // Field and register widths
  localparam int FLD_W    = 8;
  localparam int CFG_W    = 9;
  localparam int OPC_W    = 2;
  localparam int DIST_W   = 9;

  // Compare widths wide enough for both operands
  localparam int CMP_W    = (CFG_W > DIM_W) ? CFG_W : DIM_W;
  localparam int IC_W     = (FLD_W > DIM_W) ? FLD_W : DIM_W;

  // Distance codes: all ones marks "no set pixel reachable"
  localparam logic [DIST_W-1:0] DIST_NONE = '1;
  localparam logic [DIST_W-1:0] DIST_SAT  = DIST_NONE - DIST_W'(1);

  // Opcodes
  localparam logic [OPC_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OPC_W-1:0] OP_RUN   = 2'd1;
  localparam logic [OPC_W-1:0] OP_READ  = 2'd2;

  // Register indexes
  localparam logic CFG_ROW_COUNT = 1'b0;
  localparam logic CFG_COL_COUNT = 1'b1;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [DIM_W-1:0]  dim_t;
  typedef logic [DIST_W-1:0] dist_t;

  // Memory requests from the scan sequencer
  typedef struct packed {
    logic  pix_re;
    addr_t pix_raddr;
    logic  dist_re_a;
    addr_t dist_addr_a;
    logic  dist_re_b;
    addr_t dist_addr_b;
    logic  dist_we;
    addr_t dist_waddr;
    dist_t dist_wdata;
  } scan_mem_t;

  // Row-major pixel address
  function automatic addr_t pix_addr(idx_t r, idx_t c);
    return {r, c};
  endfunction

  // Register value to active size: zero counts as one, saturate at MAX_DIM
  function automatic dim_t clamp_dim(logic [CFG_W-1:0] v);
    logic [CMP_W-1:0] w;
    w = CMP_W'(v);
    if (w == '0) return DIM_W'(1);
    if (w > CMP_W'(MAX_DIM)) return DIM_W'(MAX_DIM);
    return DIM_W'(w);
  endfunction

endpackage

// ===== sv/mdt_in_if.sv =====
// Input item channel: opcode, pixel coordinates and pixel value.
`timescale 1ns / 1ps

interface mdt_in_if;
  import mdt_pkg::*;

  logic             valid;
  logic             ready;
  logic [OPC_W-1:0] opcode;
  logic [FLD_W-1:0] row_index;
  logic [FLD_W-1:0] col_index;
  logic             pixel_set;

  modport source (
    output valid, opcode, row_index, col_index, pixel_set,
    input  ready
  );

  modport sink (
    input  valid, opcode, row_index, col_index, pixel_set,
    output ready
  );
endinterface

// ===== sv/mdt_out_if.sv =====
// Result item channel: one distance per read.
`timescale 1ns / 1ps

interface mdt_out_if;
  import mdt_pkg::*;

  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] distance;

  modport source (
    output valid, distance,
    input  ready
  );

  modport sink (
    input  valid, distance,
    output ready
  );
endinterface

// ===== sv/mdt_pixel_mem.sv =====
// Bitmap memory: one write port, one read port, registered read data.
`timescale 1ns / 1ps

module mdt_pixel_mem (
  input  logic          clk_i,
  input  logic          we_i,
  input  mdt_pkg::addr_t waddr_i,
  input  logic          wdata_i,
  input  logic          re_i,
  input  mdt_pkg::addr_t raddr_i,
  output logic          rdata_o
);
  import mdt_pkg::*;

  logic mem [DEPTH];
  logic rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/mdt_dist_mem.sv =====
// Distance memory: one write port, two read ports, registered read data.
`timescale 1ns / 1ps

module mdt_dist_mem (
  input  logic           clk_i,
  input  logic           we_i,
  input  mdt_pkg::addr_t waddr_i,
  input  mdt_pkg::dist_t wdata_i,
  input  logic           re_a_i,
  input  mdt_pkg::addr_t raddr_a_i,
  output mdt_pkg::dist_t rdata_a_o,
  input  logic           re_b_i,
  input  mdt_pkg::addr_t raddr_b_i,
  output mdt_pkg::dist_t rdata_b_o
);
  import mdt_pkg::*;

  dist_t mem [DEPTH];
  dist_t rdata_a_q;
  dist_t rdata_b_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read ports, data held until the next read on that port
  always_ff @(posedge clk_i) begin
    if (re_a_i) begin
      rdata_a_q <= mem[raddr_a_i];
    end
    if (re_b_i) begin
      rdata_b_q <= mem[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ===== sv/mdt_scan.sv =====
// Raster scan sequencer: forward then backward pass over the distance memory.
`timescale 1ns / 1ps

module mdt_scan (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  mdt_pkg::dim_t      nr_i,
  input  mdt_pkg::dim_t      nc_i,
  input  logic               pix_rdata_i,
  input  mdt_pkg::dist_t     dist_a_i,
  input  mdt_pkg::dist_t     dist_b_i,
  output mdt_pkg::scan_mem_t mem_o,
  output logic               busy_o
);
  import mdt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FWD,
    S_GAP,
    S_BWD,
    S_DRAIN
  } state_e;

  state_e state_q, state_d;
  idx_t   row_q, row_d, col_q, col_d;
  logic   cv_q, cv_d;
  logic   cfwd_q;
  idx_t   crow_q, ccol_q;
  dist_t  prev_q;

  idx_t   nr_m1, nc_m1;
  logic   last_col, last_row;
  logic   issue;
  dist_t  vert, dist_new;

  // Relax against a neighbor: take neighbor + 1 when smaller
  function automatic dist_t relax(dist_t cur, dist_t nb);
    dist_t inc;
    inc = (nb >= DIST_SAT) ? DIST_SAT : nb + DIST_W'(1);
    if (nb != DIST_NONE && inc < cur) return inc;
    return cur;
  endfunction

  assign nr_m1    = IDX_W'(nr_i - DIM_W'(1));
  assign nc_m1    = IDX_W'(nc_i - DIM_W'(1));
  assign last_col = (col_q == nc_m1);
  assign last_row = (row_q == nr_m1);
  assign issue    = (state_q == S_FWD) || (state_q == S_BWD);

  // Pixel walk; a gap state between the passes lets the last forward write land
  always_comb begin
    state_d = state_q;
    row_d   = row_q;
    col_d   = col_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = S_FWD;
          row_d   = '0;
          col_d   = '0;
        end
      end
      S_FWD: begin
        if (last_col) begin
          col_d = '0;
          if (last_row) state_d = S_GAP;
          else          row_d   = row_q + IDX_W'(1);
        end else begin
          col_d = col_q + IDX_W'(1);
        end
      end
      S_GAP: begin
        state_d = S_BWD;
        row_d   = nr_m1;
        col_d   = nc_m1;
      end
      S_BWD: begin
        if (col_q == '0) begin
          col_d = nc_m1;
          if (row_q == '0) state_d = S_DRAIN;
          else             row_d   = row_q - IDX_W'(1);
        end else begin
          col_d = col_q - IDX_W'(1);
        end
      end
      S_DRAIN: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign cv_d = issue;

  // Compute stage: neighbor above/below comes from memory, or from the
  // previous result when a row is one pixel wide
  always_comb begin
    if (cfwd_q) begin
      vert     = (nc_m1 == '0) ? prev_q : dist_a_i;
      dist_new = pix_rdata_i ? '0 : DIST_NONE;
      if (crow_q != '0) dist_new = relax(dist_new, vert);
      if (ccol_q != '0) dist_new = relax(dist_new, prev_q);
    end else begin
      vert     = (nc_m1 == '0) ? prev_q : dist_b_i;
      dist_new = dist_a_i;
      if (crow_q != nr_m1) dist_new = relax(dist_new, vert);
      if (ccol_q != nc_m1) dist_new = relax(dist_new, prev_q);
    end
  end

  // Memory requests
  always_comb begin
    mem_o.pix_re      = (state_q == S_FWD);
    mem_o.pix_raddr   = pix_addr(row_q, col_q);
    mem_o.dist_re_a   = issue;
    mem_o.dist_addr_a = (state_q == S_FWD) ? pix_addr(row_q - IDX_W'(1), col_q)
                                           : pix_addr(row_q, col_q);
    mem_o.dist_re_b   = (state_q == S_BWD);
    mem_o.dist_addr_b = pix_addr(row_q + IDX_W'(1), col_q);
    mem_o.dist_we     = cv_q;
    mem_o.dist_waddr  = pix_addr(crow_q, ccol_q);
    mem_o.dist_wdata  = dist_new;
  end

  assign busy_o = (state_q != S_IDLE);

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cv_q    <= cv_d;
    end
  end

  // Walk position and compute stage payload
  always_ff @(posedge clk_i) begin
    row_q  <= row_d;
    col_q  <= col_d;
    cfwd_q <= (state_q == S_FWD);
    crow_q <= row_q;
    ccol_q <= col_q;
    if (cv_q) begin
      prev_q <= dist_new;
    end
  end

endmodule

// ===== sv/manhattan_distance_transform.sv =====
// Top level of the city-block distance transform over a stored bitmap.
`timescale 1ns / 1ps

// The block keeps a MAX_DIM x MAX_DIM bitmap and a matching distance map in
// two on-chip memories. Pixel writes and distance reads are taken one per
// cycle while no transform runs and the result side does not stall; a read
// result passes a memory stage and the output register; a read outside
// the active area returns 511. A run item starts the transform and holds
// off input transfers until it ends: a forward and a backward raster pass,
// each moving one pixel per cycle through the distance memory (one write
// port, two read ports), with a gap state between the passes and a drain
// state at the end. If the active area holds no set pixel, every distance
// reads 511. The size registers are sampled by the transform and each read;
// the user must write them only while the block is idle (not enforced).
module manhattan_distance_transform (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [mdt_pkg::CFG_W-1:0]    cfg_data_i,
  mdt_in_if.sink                       item_in,
  mdt_out_if.source                    result_out
);
  import mdt_pkg::*;

  logic [CFG_W-1:0] row_count_q, col_count_q;
  dim_t             nr, nc;

  logic             in_xfer, adv;
  logic             is_write, is_read, is_run;
  logic             in_store, in_area;
  addr_t            host_addr;

  logic             s1_valid_q, s1_valid_d;
  logic             s1_outside_q;
  logic             out_valid_q, out_valid_d;
  dist_t            out_dist_q;

  scan_mem_t        scan_mem;
  logic             scan_busy;
  logic             pix_rdata;
  dist_t            dist_a, dist_b;
  logic             dist_re_a;
  addr_t            dist_addr_a;

  // Size registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= CFG_W'(1);
      col_count_q <= CFG_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ROW_COUNT: row_count_q <= cfg_data_i;
        CFG_COL_COUNT: col_count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign nr = clamp_dim(row_count_q);
  assign nc = clamp_dim(col_count_q);

  // Input decode
  assign adv        = !out_valid_q || result_out.ready;
  assign item_in.ready = !scan_busy && (!s1_valid_q || adv);
  assign in_xfer    = item_in.valid && item_in.ready;
  assign is_write   = in_xfer && (item_in.opcode == OP_WRITE);
  assign is_run     = in_xfer && (item_in.opcode == OP_RUN);
  assign is_read    = in_xfer && (item_in.opcode == OP_READ);
  assign in_store   = (IC_W'(item_in.row_index) < IC_W'(MAX_DIM)) &&
                      (IC_W'(item_in.col_index) < IC_W'(MAX_DIM));
  assign in_area    = (IC_W'(item_in.row_index) < IC_W'(nr)) &&
                      (IC_W'(item_in.col_index) < IC_W'(nc));
  assign host_addr  = pix_addr(IDX_W'(item_in.row_index), IDX_W'(item_in.col_index));

  // Read port A is shared: the scan owns it while busy
  assign dist_re_a   = scan_busy ? scan_mem.dist_re_a : (is_read && in_area);
  assign dist_addr_a = scan_busy ? scan_mem.dist_addr_a : host_addr;

  mdt_pixel_mem u_pixel_mem (
    .clk_i   (clk_i),
    .we_i    (is_write && in_store),
    .waddr_i (host_addr),
    .wdata_i (item_in.pixel_set),
    .re_i    (scan_mem.pix_re),
    .raddr_i (scan_mem.pix_raddr),
    .rdata_o (pix_rdata)
  );

  mdt_dist_mem u_dist_mem (
    .clk_i     (clk_i),
    .we_i      (scan_mem.dist_we),
    .waddr_i   (scan_mem.dist_waddr),
    .wdata_i   (scan_mem.dist_wdata),
    .re_a_i    (dist_re_a),
    .raddr_a_i (dist_addr_a),
    .rdata_a_o (dist_a),
    .re_b_i    (scan_mem.dist_re_b),
    .raddr_b_i (scan_mem.dist_addr_b),
    .rdata_b_o (dist_b)
  );

  mdt_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (is_run),
    .nr_i        (nr),
    .nc_i        (nc),
    .pix_rdata_i (pix_rdata),
    .dist_a_i    (dist_a),
    .dist_b_i    (dist_b),
    .mem_o       (scan_mem),
    .busy_o      (scan_busy)
  );

  // Read pipeline: memory stage then output register
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (is_read)  s1_valid_d = 1'b1;
    else if (adv) s1_valid_d = 1'b0;
    out_valid_d = adv ? s1_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_read) begin
      s1_outside_q <= !in_area;
    end
    if (adv && s1_valid_q) begin
      out_dist_q <= s1_outside_q ? DIST_NONE : dist_a;
    end
  end

  assign result_out.valid    = out_valid_q;
  assign result_out.distance = out_dist_q;

endmodule

// ===== tb/manhattan_distance_transform_test.sv =====
// Self-checking testbench for the city-block distance transform block.
`timescale 1ns / 1ps

module manhattan_distance_transform_test;
  import mdt_pkg::*;

  // Opcode the block ignores
  localparam logic [OPC_W-1:0] OP_SPARE = 2'd3;

  localparam int WORK_INF        = 'hFFFF;
  localparam int CYCLE_LIMIT     = 500_000;
  localparam int RANDOM_ITEMS    = 500;
  localparam int HOLD_OFF_CYCLES = 300;

  typedef enum int {FILL_EMPTY, FILL_SINGLE, FILL_SPARSE, FILL_DENSE} fill_kind_e;

  // Bitmap, distance map and size registers as the block should hold them,
  // plus the distances still owed by the block, oldest first.
  class distance_map_model;
    logic [CFG_W-1:0] rows_reg;
    logic [CFG_W-1:0] cols_reg;
    bit               pix_mem    [DEPTH];
    bit               pix_known  [DEPTH];
    bit               dist_known [DEPTH];
    int               dist_mem   [DEPTH];
    dist_t            due_distances [$];
    int               items_taken;
    int               distances_checked;
    int               transforms_run;
    int               largest_area;
    int               mismatches;

    function new();
      rows_reg = CFG_W'(1);
      cols_reg = CFG_W'(1);
    endfunction

    // Zero counts as one, anything past the store saturates
    function int area_size(logic [CFG_W-1:0] v);
      if (v == '0) return 1;
      if (int'(v) > MAX_DIM) return MAX_DIM;
      return int'(v);
    endfunction

    function int area_rows();
      return area_size(rows_reg);
    endfunction

    function int area_cols();
      return area_size(cols_reg);
    endfunction

    function void write_register(logic idx, logic [CFG_W-1:0] v);
      if (idx == CFG_ROW_COUNT) rows_reg = v;
      else cols_reg = v;
    endfunction

    function int step_from(int cur, int nb);
      if (nb != WORK_INF && nb + 1 < cur) return nb + 1;
      return cur;
    endfunction

    // Forward and backward raster scan over the active area
    function void run_transform();
      int nr, nc, a, d;
      bit any_set;
      nr = area_rows();
      nc = area_cols();
      any_set = 1'b0;
      for (int r = 0; r < nr; r++) begin
        for (int c = 0; c < nc; c++) begin
          a = r * MAX_DIM + c;
          d = pix_mem[a] ? 0 : WORK_INF;
          if (pix_mem[a]) any_set = 1'b1;
          if (r > 0) d = step_from(d, dist_mem[a - MAX_DIM]);
          if (c > 0) d = step_from(d, dist_mem[a - 1]);
          dist_mem[a] = d;
          dist_known[a] = 1'b1;
        end
      end
      for (int r = nr - 1; r >= 0; r--) begin
        for (int c = nc - 1; c >= 0; c--) begin
          a = r * MAX_DIM + c;
          d = dist_mem[a];
          if (r + 1 < nr) d = step_from(d, dist_mem[a + MAX_DIM]);
          if (c + 1 < nc) d = step_from(d, dist_mem[a + 1]);
          dist_mem[a] = d;
        end
      end
      // no set pixel, or unreachable: all ones; else saturate
      for (int r = 0; r < nr; r++) begin
        for (int c = 0; c < nc; c++) begin
          a = r * MAX_DIM + c;
          if (!any_set || dist_mem[a] == WORK_INF) dist_mem[a] = int'(DIST_NONE);
          else if (dist_mem[a] > int'(DIST_SAT)) dist_mem[a] = int'(DIST_SAT);
        end
      end
      transforms_run++;
      if (nr * nc > largest_area) largest_area = nr * nc;
    endfunction

    // Called for every accepted input transfer
    function void note_item(logic [OPC_W-1:0] op, logic [FLD_W-1:0] r,
                            logic [FLD_W-1:0] c, logic px);
      int a, d;
      a = int'(r) * MAX_DIM + int'(c);
      case (op)
        OP_WRITE: begin
          pix_mem[a] = px;
          pix_known[a] = 1'b1;
          items_taken++;
        end
        OP_RUN: begin
          run_transform();
          items_taken++;
        end
        OP_READ: begin
          d = int'(DIST_NONE);
          if (int'(r) < area_rows() && int'(c) < area_cols()) d = dist_mem[a];
          due_distances = {due_distances, dist_t'(d)};
          items_taken++;
        end
        default: ;
      endcase
    endfunction

    // Called for every accepted result transfer
    function void check_distance(dist_t got);
      dist_t want;
      if (due_distances.size() == 0) begin
        $display("%0t: distance expected none, got %0d", $time, got);
        mismatches++;
      end else begin
        want = due_distances.pop_front();
        distances_checked++;
        if (got !== want) begin
          $display("%0t: distance expected %0d, got %0d", $time, want, got);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic             cfg_idx_i;
  logic [CFG_W-1:0] cfg_data_i;

  mdt_in_if  item_if ();
  mdt_out_if result_if ();

  distance_map_model dmap;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_left;
  int random_items;
  int cycle_count;

  manhattan_distance_transform dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .item_in    (item_if),
    .result_out (result_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Watch both channels; input side first so a read is owed before it is paid
  always @(posedge clk_i) begin
    if (item_if.valid && item_if.ready)
      dmap.note_item(item_if.opcode, item_if.row_index, item_if.col_index,
                     item_if.pixel_set);
    if (result_if.valid && result_if.ready)
      dmap.check_distance(result_if.distance);
  end

  // Result side: random stalls, or a long hold-off when one is requested
  initial begin
    result_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        result_if.ready <= 1'b0;
        hold_left--;
      end else begin
        result_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("%0t: cycle limit reached", $time);
    $display("manhattan_distance_transform_test: errors");
    $finish;
  end

  // One input transfer, with random idle cycles ahead of it
  task automatic send_item(logic [OPC_W-1:0] op, int r, int c, bit px);
    while ($urandom_range(99) < send_idle_pct) begin
      item_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    item_if.valid     <= 1'b1;
    item_if.opcode    <= op;
    item_if.row_index <= FLD_W'(r);
    item_if.col_index <= FLD_W'(c);
    item_if.pixel_set <= px;
    do @(posedge clk_i); while (item_if.ready !== 1'b1);
    if (op != OP_SPARE) random_items++;
  endtask

  // Both size registers; only called while the block is idle
  task automatic set_area(int rows_val, int cols_val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_ROW_COUNT;
    cfg_data_i <= CFG_W'(rows_val);
    @(posedge clk_i);
    dmap.write_register(CFG_ROW_COUNT, CFG_W'(rows_val));
    cfg_idx_i  <= CFG_COL_COUNT;
    cfg_data_i <= CFG_W'(cols_val);
    @(posedge clk_i);
    dmap.write_register(CFG_COL_COUNT, CFG_W'(cols_val));
    cfg_we_i   <= 1'b0;
  endtask

  // Wait for every owed distance, then idle a while as margin
  task automatic settle();
    item_if.valid <= 1'b0;
    @(posedge clk_i);
    while (dmap.due_distances.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Read a pixel whose distance is defined, or one outside the active area
  task automatic read_somewhere(bit want_inside);
    int nr, nc, r, c;
    bit found;
    nr = dmap.area_rows();
    nc = dmap.area_cols();
    found = 1'b0;
    if (want_inside) begin
      for (int k = 0; k < 8 && !found; k++) begin
        r = $urandom_range(nr - 1);
        c = $urandom_range(nc - 1);
        found = dmap.dist_known[r * MAX_DIM + c];
      end
    end
    if (!found) begin
      if (nr < MAX_DIM && (nc == MAX_DIM || $urandom_range(1))) begin
        r = $urandom_range(MAX_DIM - 1, nr);
        c = $urandom_range(MAX_DIM - 1);
      end else begin
        c = $urandom_range(MAX_DIM - 1, nc);
        r = $urandom_range(MAX_DIM - 1);
      end
    end
    send_item(OP_READ, r, c, $urandom_range(1));
  endtask

  // Ignored opcode, stray pixel write anywhere, or a read
  task automatic send_noise();
    case ($urandom_range(2))
      0: send_item(OP_SPARE, $urandom_range(255), $urandom_range(255), $urandom_range(1));
      1: send_item(OP_WRITE, $urandom_range(255), $urandom_range(255), $urandom_range(1));
      default: read_somewhere(1'b1);
    endcase
  endtask

  // Write every unwritten pixel of the area, and some or all of the rest
  task automatic fill_area(fill_kind_e kind);
    int nr, nc, a, seed_r, seed_c;
    bit rewrite_all, v;
    nr = dmap.area_rows();
    nc = dmap.area_cols();
    seed_r = $urandom_range(nr - 1);
    seed_c = $urandom_range(nc - 1);
    rewrite_all = (kind == FILL_EMPTY) || (kind == FILL_SINGLE) || ($urandom_range(3) == 0);
    for (int r = 0; r < nr; r++) begin
      for (int c = 0; c < nc; c++) begin
        a = r * MAX_DIM + c;
        if (!dmap.pix_known[a] || rewrite_all || $urandom_range(1)) begin
          case (kind)
            FILL_EMPTY:  v = 1'b0;
            FILL_SINGLE: v = (r == seed_r) && (c == seed_c);
            FILL_SPARSE: v = ($urandom_range(99) < 4);
            default:     v = ($urandom_range(99) < 40);
          endcase
          send_item(OP_WRITE, r, c, v);
          if ($urandom_range(99) < 4) send_noise();
        end
      end
    end
  endtask

  // New size, fresh bitmap content, transform, then a burst of reads
  task automatic run_phase(int p);
    int rows_val, cols_val, reads_n, pick;
    fill_kind_e kind;
    case (p % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
      default: begin send_idle_pct = 10; recv_stall_pct = 10; end
    endcase
    pick = $urandom_range(99);
    if (p == 2) begin
      rows_val = 511;
      cols_val = $urandom_range(1);
    end else if (pick < 3) begin
      rows_val = $urandom_range(510, 256);
      cols_val = $urandom_range(1);
    end else if (pick < 6) begin
      rows_val = $urandom_range(1);
      cols_val = $urandom_range(510, 256);
    end else if (pick < 19) begin
      rows_val = $urandom_range(24, 9);
      cols_val = $urandom_range(24, 9);
    end else begin
      rows_val = $urandom_range(8);
      cols_val = $urandom_range(8);
    end
    set_area(rows_val, cols_val);

    // Now and then the size changes with no new transform behind it
    if (p == 0 || $urandom_range(99) < 85) begin
      kind = fill_kind_e'($urandom_range(3));
      fill_area(kind);
      send_item(OP_RUN, $urandom_range(255), $urandom_range(255), $urandom_range(1));
    end

    // The hold-off phase lets the result side fill up and back-pressure input
    if (p == 3) begin
      send_idle_pct = 0;
      hold_left = HOLD_OFF_CYCLES;
      reads_n = 80;
    end else begin
      reads_n = $urandom_range(30, 6);
    end
    repeat (reads_n) begin
      pick = $urandom_range(99);
      if (pick < 78) read_somewhere(1'b1);
      else if (pick < 90) read_somewhere(1'b0);
      else send_noise();
    end
    read_somewhere(1'b1);
    settle();
  endtask

  initial begin
    dmap = new();
    rst_ni            <= 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_idx_i         <= CFG_ROW_COUNT;
    cfg_data_i        <= '0;
    item_if.valid     <= 1'b0;
    item_if.opcode    <= OP_WRITE;
    item_if.row_index <= '0;
    item_if.col_index <= '0;
    item_if.pixel_set <= 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset size 1x1: empty area, then one set pixel, reads past the area,
    // ignored opcode, and a write outside the area that must be kept
    send_item(OP_WRITE, 0, 0, 1'b0);
    send_item(OP_RUN, 0, 0, 1'b0);
    send_item(OP_READ, 0, 0, 1'b0);
    send_item(OP_WRITE, 0, 0, 1'b1);
    send_item(OP_SPARE, 255, 255, 1'b1);
    send_item(OP_WRITE, 255, 255, 1'b1);
    send_item(OP_WRITE, 170, 85, 1'b0);
    send_item(OP_RUN, 255, 255, 1'b1);
    send_item(OP_READ, 0, 0, 1'b1);
    send_item(OP_READ, 0, 1, 1'b0);
    send_item(OP_READ, 255, 255, 1'b0);
    settle();

    // Zero rows counts as one; stale distance readable before the rerun
    set_area(0, 3);
    send_item(OP_WRITE, 0, 1, 1'b0);
    send_item(OP_WRITE, 0, 2, 1'b0);
    send_item(OP_READ, 0, 0, 1'b0);
    send_item(OP_RUN, 0, 0, 1'b0);
    send_item(OP_READ, 0, 2, 1'b0);
    send_item(OP_READ, 0, 1, 1'b0);
    send_item(OP_READ, 1, 0, 1'b0);
    settle();

    // Single column, distance along the rows
    set_area(2, 1);
    send_item(OP_WRITE, 1, 0, 1'b0);
    send_item(OP_RUN, 0, 0, 1'b0);
    send_item(OP_READ, 1, 0, 1'b0);
    send_item(OP_READ, 0, 0, 1'b0);
    settle();

    random_items = 0;
    for (int p = 0; random_items < RANDOM_ITEMS || p < 6; p++) run_phase(p);
    repeat (16) @(posedge clk_i);

    $display("%0d items taken, %0d distances compared, %0d transforms run",
             dmap.items_taken, dmap.distances_checked, dmap.transforms_run);
    $display("largest transformed area %0d pixels, %0d mismatches",
             dmap.largest_area, dmap.mismatches);
    if (dmap.mismatches == 0 && dmap.due_distances.size() == 0) begin
      $display("manhattan_distance_transform_test: clean");
    end else begin
      $display("manhattan_distance_transform_test: errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/mdt_pkg.sv
sv/mdt_in_if.sv
sv/mdt_out_if.sv
sv/mdt_pixel_mem.sv
sv/mdt_dist_mem.sv
sv/mdt_scan.sv
sv/manhattan_distance_transform.sv
tb/manhattan_distance_transform_test.sv
